@@ src/quadrature_encoder_detent_button_macros.svh @@
// ----------------------------------------------------------------------------
// quadrature encoder detent button assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_DETENT_BUTTON_MACROS_SVH
`define QUADRATURE_ENCODER_DETENT_BUTTON_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication check
`define QEDB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qedb check failed");

// next-cycle implication check
`define QEDB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qedb check failed");

`else

`define QEDB_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define QEDB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ src/qedb_pkg.sv @@
// ----------------------------------------------------------------------------
// qedb_pkg
// types, constants and the quadrature table for the encoder/button decoder
// ----------------------------------------------------------------------------
`default_nettype none

package qedb_pkg;

    // default number of encoders sharing the datapath
    localparam int DEFAULT_NUM_ENCODERS = 4;

    // configuration register reset values
    localparam logic [2:0] DETENT_RESET   = 3'd4;
    localparam logic [3:0] DEBOUNCE_RESET = 4'd3;

    // configuration register indexes
    typedef enum logic {
        CFG_DETENT   = 1'b0,
        CFG_DEBOUNCE = 1'b1
    } t_cfg_idx;

    // input operation codes
    typedef enum logic {
        OP_SCAN  = 1'b0,
        OP_PRIME = 1'b1
    } t_op;

    // signed turn step / table delta
    typedef logic signed [1:0] t_step;

    localparam t_step STEP_NONE = 2'sb00;
    localparam t_step STEP_CW   = 2'sb01;
    localparam t_step STEP_CCW  = 2'sb11;

    // 4-state quadrature table, index {previous_ab, current_ab}
    localparam t_step QUAD_TABLE [16] = '{
        STEP_NONE, STEP_CW,   STEP_CCW,  STEP_NONE,
        STEP_CCW,  STEP_NONE, STEP_NONE, STEP_CW,
        STEP_CW,   STEP_NONE, STEP_NONE, STEP_CCW,
        STEP_NONE, STEP_CCW,  STEP_CW,   STEP_NONE
    };

    // table lookup for one transition
    function automatic t_step quad_delta(input logic [1:0] prev_ab,
                                         input logic [1:0] cur_ab);
        return QUAD_TABLE[{prev_ab, cur_ab}];
    endfunction

endpackage

`default_nettype wire

@@ src/quadrature_encoder_detent_button.sv @@
// result path: an accepted item is held in the input register, then the result register
// throughput: one item per cycle while not stalled, limited by the single
//   per-encoder state read-modify-write between input and result registers
// reset: synchronous active low; clears pipeline valids, per-encoder state
//   and loads the detent and debounce registers with their defaults
// ----------------------------------------------------------------------------
// quadrature_encoder_detent_button
// quadrature decode with detent counting and push-button debounce for
// several encoders on one shared datapath
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadrature_encoder_detent_button_macros.svh"

module quadrature_encoder_detent_button
    import qedb_pkg::*;
#(
    parameter int NUM_ENCODERS = DEFAULT_NUM_ENCODERS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration write port
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [3:0]        i_cfg_data,
    // input item channel
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_operation,
    input  wire logic [1:0]        i_encoder_index,
    input  wire logic              i_phase_a,
    input  wire logic              i_phase_b,
    input  wire logic              i_button_active,
    // result item channel
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [2:0]             o_encoder_number,
    output logic signed [1:0]      o_turn_step,
    output logic                   o_click
);

    localparam int IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    // configuration registers
    logic [2:0] r_detent;
    logic [3:0] r_debounce;

    // per-encoder state
    logic [1:0]        r_prev_ab     [NUM_ENCODERS];
    logic signed [3:0] r_acc         [NUM_ENCODERS];
    logic [3:0]        r_btn_cnt     [NUM_ENCODERS];
    logic              r_btn_pressed [NUM_ENCODERS];

    // input register
    logic       r_s1_valid;
    logic       r_s1_op;
    logic [1:0] r_s1_enc;
    logic       r_s1_a;
    logic       r_s1_b;
    logic       r_s1_btn;

    // result register
    logic        r_out_valid;
    logic [2:0]  r_out_enc_num;
    t_step       r_out_step;
    logic        r_out_click;

    logic n_s1_valid;
    logic n_out_valid;

    // handshake control
    logic w_out_free;
    logic w_load;
    logic w_accept;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_load     = r_s1_valid && w_out_free;
    assign o_stall    = r_s1_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_load) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_free) begin
            n_out_valid = w_load;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detent   <= DETENT_RESET;
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DETENT:   r_detent   <= i_cfg_data[2:0];
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                default:      r_debounce <= r_debounce;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op  <= i_operation;
            r_s1_enc <= i_encoder_index;
            r_s1_a   <= i_phase_a;
            r_s1_b   <= i_phase_b;
            r_s1_btn <= i_button_active;
        end
    end

    // decode of the held item against its encoder state
    logic              w_in_range;
    logic              w_scan;
    logic [IDX_W-1:0]  w_sel;
    logic [1:0]        w_ab;
    logic signed [3:0] w_acc_cur;
    logic [2:0]        w_det;
    logic [3:0]        w_deb;
    logic signed [4:0] w_sum;
    logic signed [4:0] w_det_s;
    logic signed [4:0] w_adj;
    t_step             w_delta;
    t_step             w_step;
    logic [4:0]        w_cnt_raw;
    logic [4:0]        w_cnt_sat;
    logic              w_now_pressed;
    logic              w_click;

    assign w_in_range = (int'(r_s1_enc) < NUM_ENCODERS);
    assign w_scan     = (t_op'(r_s1_op) == OP_SCAN);
    assign w_sel      = IDX_W'(r_s1_enc);
    assign w_ab       = {r_s1_a, r_s1_b};
    assign w_acc_cur  = r_acc[w_sel];
    assign w_det      = (r_detent == 3'd0) ? 3'd1 : r_detent;
    assign w_deb      = (r_debounce == 4'd0) ? 4'd1 : r_debounce;
    assign w_delta    = quad_delta(r_prev_ab[w_sel], w_ab);
    assign w_sum      = {w_acc_cur[3], w_acc_cur} + {{3{w_delta[1]}}, w_delta};
    assign w_det_s    = {2'b00, w_det};

    // detent threshold, at most one step per sample
    always_comb begin
        priority if (w_sum >= w_det_s) begin
            w_adj  = w_sum - w_det_s;
            w_step = STEP_CW;
        end else if (w_sum <= -w_det_s) begin
            w_adj  = w_sum + w_det_s;
            w_step = STEP_CCW;
        end else begin
            w_adj  = w_sum;
            w_step = STEP_NONE;
        end
    end

    // saturating debounce counter and press edge
    assign w_cnt_raw     = r_s1_btn ? ({1'b0, r_btn_cnt[w_sel]} + 5'd1) : 5'd0;
    assign w_cnt_sat     = (w_cnt_raw > {1'b0, w_deb}) ? {1'b0, w_deb} : w_cnt_raw;
    assign w_now_pressed = (w_cnt_sat == {1'b0, w_deb});
    assign w_click       = w_now_pressed && !r_btn_pressed[w_sel];

    // per-encoder state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ENCODERS; k++) begin
                r_prev_ab[k]     <= 2'd0;
                r_acc[k]         <= 4'sd0;
                r_btn_cnt[k]     <= 4'd0;
                r_btn_pressed[k] <= 1'b0;
            end
        end else if (w_load && w_in_range) begin
            r_prev_ab[w_sel] <= w_ab;
            if (w_scan) begin
                r_acc[w_sel]         <= w_adj[3:0];
                r_btn_cnt[w_sel]     <= w_cnt_sat[3:0];
                r_btn_pressed[w_sel] <= w_now_pressed;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_enc_num <= {1'b0, r_s1_enc} + 3'd1;
            if (w_in_range && w_scan) begin
                r_out_step  <= w_step;
                r_out_click <= w_click;
            end else begin
                r_out_step  <= STEP_NONE;
                r_out_click <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_encoder_number = r_out_enc_num;
    assign o_turn_step      = r_out_step;
    assign o_click          = r_out_click;

    // checks
    `QEDB_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, !r_out_valid, !o_stall)
    `QEDB_ASSERT_NOW(a_step_code_legal, i_clk, i_rst_n, o_valid, o_turn_step != 2'sb10)
    `QEDB_ASSERT_NOW(a_acc_in_range, i_clk, i_rst_n,
        r_s1_valid && w_in_range, w_acc_cur != 4'sb1000)
    `QEDB_ASSERT_NEXT(a_click_reaches_out, i_clk, i_rst_n,
        w_load && w_in_range && w_scan && w_click, o_valid && o_click)
    `QEDB_ASSERT_NOW(a_idle_encoder_quiet, i_clk, i_rst_n,
        o_valid && (int'(o_encoder_number) > NUM_ENCODERS),
        (o_turn_step == STEP_NONE) && !o_click)

endmodule

`default_nettype wire
